[rtl/infix_to_prefix_converter_macros.svh]
// Assertion macros shared by the infix-to-prefix converter RTL.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef INFIX_TO_PREFIX_CONVERTER_MACROS_SVH
`define INFIX_TO_PREFIX_CONVERTER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ITP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define ITP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/itp_pkg.sv]
// Package for the infix-to-prefix converter: character constants, state and
// class enums, controller/datapath command and status structs, helper functions.
// No dependencies.
`default_nettype none

package itp_pkg;

  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_NUL    = 8'h00;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_PAREN = 2'd1;
  localparam logic [1:0] STATUS_TRUNC = 2'd2;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SCAN_RD,
    ST_SCAN_EX,
    ST_CLOSE_RD,
    ST_CLOSE_EX,
    ST_OPER_RD,
    ST_OPER_EX,
    ST_DRAIN_RD,
    ST_DRAIN_EX,
    ST_OUT_EMPTY,
    ST_OUT_RD,
    ST_OUT_LD
  } state_e;

  typedef enum logic [1:0] {
    CLS_ALNUM,
    CLS_OPEN,
    CLS_CLOSE,
    CLS_OPER
  } chr_class_e;

  typedef struct packed {
    logic load;
    logic ld_k_in;
    logic ld_k_out;
    logic rd_in;
    logic latch_cur;
    logic emit_scan;
    logic emit_top;
    logic push_scan;
    logic push_cur;
    logic rd_stk;
    logic pop;
    logic set_paren;
    logic rd_out;
    logic load_out;
    logic load_empty;
    logic clr;
  } itp_cmd_t;

  typedef struct packed {
    logic       k_zero;
    logic       depth_zero;
    logic       ocnt_zero;
    chr_class_e cls;
    logic       top_open;
    logic       top_gt;
    logic       out_free;
  } itp_sts_t;

  function automatic logic is_alnum(input logic [7:0] c);
    return c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]};
  endfunction

  function automatic logic [1:0] rank_of(input logic [7:0] c);
    logic [1:0] r;
    case (c)
      CH_PLUS, CH_MINUS: r = 2'd1;
      CH_STAR, CH_SLASH: r = 2'd2;
      CH_CARET:          r = 2'd3;
      default:           r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] swap_paren(input logic [7:0] c);
    logic [7:0] r;
    case (c)
      CH_LPAREN: r = CH_RPAREN;
      CH_RPAREN: r = CH_LPAREN;
      default:   r = c;
    endcase
    return r;
  endfunction

  function automatic chr_class_e class_of(input logic [7:0] c);
    chr_class_e r;
    if (is_alnum(c)) begin
      r = CLS_ALNUM;
    end else if (c == CH_LPAREN) begin
      r = CLS_OPEN;
    end else if (c == CH_RPAREN) begin
      r = CLS_CLOSE;
    end else begin
      r = CLS_OPER;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/itp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module itp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[rtl/itp_dp.sv]
// Datapath of the infix-to-prefix converter: input, operator stack and output
// buffers, their counters, error flags and the output register.
// Depends on itp_pkg, itp_ram and infix_to_prefix_converter_macros.svh.
`default_nettype none
`include "infix_to_prefix_converter_macros.svh"

module itp_dp #(
  parameter int unsigned MAX_LEN = 64
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [7:0]       char_in_i,
  input  wire itp_pkg::itp_cmd_t cmd_i,
  output itp_pkg::itp_sts_t     sts_o,
  input  wire logic             out_stall_i,
  output logic                  out_valid_o,
  output logic      [7:0]       char_out_o,
  output logic                  last_out_o,
  output logic                  empty_out_o,
  output logic      [1:0]       status_o
);

  localparam int unsigned AW = $clog2(MAX_LEN);
  localparam int unsigned CW = $clog2(MAX_LEN + 1);
  localparam logic [CW-1:0] FullCnt = CW'(MAX_LEN);
  localparam logic [CW-1:0] OneCnt  = CW'(1);

  logic [CW-1:0] in_cnt_q, in_cnt_d;
  logic [CW-1:0] k_q, k_d;
  logic [CW-1:0] depth_q, depth_d;
  logic [CW-1:0] ocnt_q, ocnt_d;
  logic          paren_q, paren_d;
  logic          trunc_q, trunc_d;
  logic          out_valid_q, out_valid_d;
  logic [7:0]    cur_q;
  logic [7:0]    out_char_q;
  logic          out_last_q;
  logic          out_empty_q;
  logic [1:0]    out_status_q;

  logic [CW-1:0] k_dec;
  logic [CW-1:0] depth_dec;
  logic          in_full, stk_full, out_full;
  logic          push, emit, out_free;
  logic [7:0]    ibuf_rdata, stk_rdata, obuf_rdata;
  logic [7:0]    scan_c;
  logic [7:0]    stk_wdata, obuf_wdata;
  logic [1:0]    expr_status;

  assign k_dec     = k_q - OneCnt;
  assign depth_dec = depth_q - OneCnt;
  assign in_full   = (in_cnt_q == FullCnt);
  assign stk_full  = (depth_q == FullCnt);
  assign out_full  = (ocnt_q == FullCnt);
  assign push      = cmd_i.push_scan | cmd_i.push_cur;
  assign emit      = cmd_i.emit_scan | cmd_i.emit_top;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign scan_c    = itp_pkg::swap_paren(ibuf_rdata);
  assign stk_wdata  = cmd_i.push_scan ? scan_c : cur_q;
  assign obuf_wdata = cmd_i.emit_scan ? scan_c : stk_rdata;

  assign expr_status = trunc_q ? itp_pkg::STATUS_TRUNC :
                       paren_q ? itp_pkg::STATUS_PAREN : itp_pkg::STATUS_OK;

  itp_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_ibuf (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load && !in_full),
    .waddr_i (in_cnt_q[AW-1:0]),
    .wdata_i (char_in_i),
    .re_i    (cmd_i.rd_in),
    .raddr_i (k_dec[AW-1:0]),
    .rdata_o (ibuf_rdata)
  );

  itp_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_stack (
    .clk_i   (clk_i),
    .we_i    (push && !stk_full),
    .waddr_i (depth_q[AW-1:0]),
    .wdata_i (stk_wdata),
    .re_i    (cmd_i.rd_stk),
    .raddr_i (depth_dec[AW-1:0]),
    .rdata_o (stk_rdata)
  );

  itp_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_obuf (
    .clk_i   (clk_i),
    .we_i    (emit && !out_full),
    .waddr_i (ocnt_q[AW-1:0]),
    .wdata_i (obuf_wdata),
    .re_i    (cmd_i.rd_out),
    .raddr_i (k_dec[AW-1:0]),
    .rdata_o (obuf_rdata)
  );

  always_comb begin
    in_cnt_d    = in_cnt_q;
    k_d         = k_q;
    depth_d     = depth_q;
    ocnt_d      = ocnt_q;
    paren_d     = paren_q;
    trunc_d     = trunc_q;
    out_valid_d = out_valid_q;

    if (cmd_i.load) begin
      if (in_full) begin
        trunc_d = 1'b1;
      end else begin
        in_cnt_d = in_cnt_q + OneCnt;
      end
    end

    if (cmd_i.ld_k_in) begin
      k_d = in_full ? in_cnt_q : in_cnt_q + OneCnt;
    end else if (cmd_i.ld_k_out) begin
      k_d = ocnt_q;
    end else if (cmd_i.rd_in || cmd_i.rd_out) begin
      k_d = k_dec;
    end

    if (push && !stk_full) begin
      depth_d = depth_q + OneCnt;
    end else if (cmd_i.pop) begin
      depth_d = depth_dec;
    end

    if (emit && !out_full) begin
      ocnt_d = ocnt_q + OneCnt;
    end

    if (cmd_i.set_paren) begin
      paren_d = 1'b1;
    end

    if (cmd_i.load_out || cmd_i.load_empty) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end

    if (cmd_i.clr) begin
      in_cnt_d = '0;
      depth_d  = '0;
      ocnt_d   = '0;
      paren_d  = 1'b0;
      trunc_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_cnt_q    <= '0;
      k_q         <= '0;
      depth_q     <= '0;
      ocnt_q      <= '0;
      paren_q     <= 1'b0;
      trunc_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_cnt_q    <= in_cnt_d;
      k_q         <= k_d;
      depth_q     <= depth_d;
      ocnt_q      <= ocnt_d;
      paren_q     <= paren_d;
      trunc_q     <= trunc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_cur) begin
      cur_q <= scan_c;
    end
    if (cmd_i.load_out) begin
      out_char_q   <= obuf_rdata;
      out_last_q   <= (k_q == '0);
      out_empty_q  <= 1'b0;
      out_status_q <= expr_status;
    end else if (cmd_i.load_empty) begin
      out_char_q   <= itp_pkg::CH_NUL;
      out_last_q   <= 1'b1;
      out_empty_q  <= 1'b1;
      out_status_q <= expr_status;
    end
  end

  assign sts_o.k_zero     = (k_q == '0);
  assign sts_o.depth_zero = (depth_q == '0);
  assign sts_o.ocnt_zero  = (ocnt_q == '0);
  assign sts_o.cls        = itp_pkg::class_of(scan_c);
  assign sts_o.top_open   = (stk_rdata == itp_pkg::CH_LPAREN);
  assign sts_o.top_gt     = (itp_pkg::rank_of(stk_rdata) > itp_pkg::rank_of(cur_q));
  assign sts_o.out_free   = out_free;

  assign out_valid_o = out_valid_q;
  assign char_out_o  = out_char_q;
  assign last_out_o  = out_last_q;
  assign empty_out_o = out_empty_q;
  assign status_o    = out_status_q;

  `ITP_ASSERT_IMPL(a_no_pop_empty, cmd_i.pop, depth_q != '0, "pop from empty operator stack")
  `ITP_ASSERT_IMPL(a_out_load_free, cmd_i.load_out || cmd_i.load_empty,
                   !out_valid_q || !out_stall_i,
                   "output register overwritten while holding a transaction")
  `ITP_ASSERT_IMPL(a_ocnt_bound, 1'b1, ocnt_q <= in_cnt_q, "more output than input characters")

endmodule

`default_nettype wire

[rtl/itp_ctrl.sv]
// Controller of the infix-to-prefix converter: sequences load, reversed scan,
// stack pops, stack drain and output emission. Depends on itp_pkg and
// infix_to_prefix_converter_macros.svh.
`default_nettype none
`include "infix_to_prefix_converter_macros.svh"

module itp_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              end_of_expr_i,
  output logic                   in_stall_o,
  input  wire itp_pkg::itp_sts_t sts_i,
  output itp_pkg::itp_cmd_t      cmd_o
);

  itp_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= itp_pkg::ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      itp_pkg::ST_LOAD: begin
        if (in_valid_i && end_of_expr_i) begin
          state_d = itp_pkg::ST_SCAN_RD;
        end
      end
      itp_pkg::ST_SCAN_RD: begin
        state_d = sts_i.k_zero ? itp_pkg::ST_DRAIN_RD : itp_pkg::ST_SCAN_EX;
      end
      itp_pkg::ST_SCAN_EX: begin
        case (sts_i.cls)
          itp_pkg::CLS_CLOSE: state_d = itp_pkg::ST_CLOSE_RD;
          itp_pkg::CLS_OPER:  state_d = itp_pkg::ST_OPER_RD;
          default:            state_d = itp_pkg::ST_SCAN_RD;
        endcase
      end
      itp_pkg::ST_CLOSE_RD: begin
        state_d = sts_i.depth_zero ? itp_pkg::ST_SCAN_RD : itp_pkg::ST_CLOSE_EX;
      end
      itp_pkg::ST_CLOSE_EX: begin
        state_d = sts_i.top_open ? itp_pkg::ST_SCAN_RD : itp_pkg::ST_CLOSE_RD;
      end
      itp_pkg::ST_OPER_RD: begin
        state_d = sts_i.depth_zero ? itp_pkg::ST_SCAN_RD : itp_pkg::ST_OPER_EX;
      end
      itp_pkg::ST_OPER_EX: begin
        state_d = sts_i.top_gt ? itp_pkg::ST_OPER_RD : itp_pkg::ST_SCAN_RD;
      end
      itp_pkg::ST_DRAIN_RD: begin
        if (!sts_i.depth_zero) begin
          state_d = itp_pkg::ST_DRAIN_EX;
        end else if (sts_i.ocnt_zero) begin
          state_d = itp_pkg::ST_OUT_EMPTY;
        end else begin
          state_d = itp_pkg::ST_OUT_RD;
        end
      end
      itp_pkg::ST_DRAIN_EX: begin
        state_d = itp_pkg::ST_DRAIN_RD;
      end
      itp_pkg::ST_OUT_EMPTY: begin
        if (sts_i.out_free) begin
          state_d = itp_pkg::ST_LOAD;
        end
      end
      itp_pkg::ST_OUT_RD: begin
        if (sts_i.out_free) begin
          state_d = itp_pkg::ST_OUT_LD;
        end
      end
      itp_pkg::ST_OUT_LD: begin
        state_d = sts_i.k_zero ? itp_pkg::ST_LOAD : itp_pkg::ST_OUT_RD;
      end
      default: state_d = itp_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      itp_pkg::ST_LOAD: begin
        in_stall_o    = 1'b0;
        cmd_o.load    = in_valid_i;
        cmd_o.ld_k_in = in_valid_i && end_of_expr_i;
      end
      itp_pkg::ST_SCAN_RD: begin
        cmd_o.rd_in = !sts_i.k_zero;
      end
      itp_pkg::ST_SCAN_EX: begin
        cmd_o.latch_cur = 1'b1;
        cmd_o.emit_scan = (sts_i.cls == itp_pkg::CLS_ALNUM);
        cmd_o.push_scan = (sts_i.cls == itp_pkg::CLS_OPEN);
      end
      itp_pkg::ST_CLOSE_RD: begin
        cmd_o.set_paren = sts_i.depth_zero;
        cmd_o.rd_stk    = !sts_i.depth_zero;
      end
      itp_pkg::ST_CLOSE_EX: begin
        cmd_o.pop      = 1'b1;
        cmd_o.emit_top = !sts_i.top_open;
      end
      itp_pkg::ST_OPER_RD: begin
        cmd_o.push_cur = sts_i.depth_zero;
        cmd_o.rd_stk   = !sts_i.depth_zero;
      end
      itp_pkg::ST_OPER_EX: begin
        cmd_o.pop      = sts_i.top_gt;
        cmd_o.emit_top = sts_i.top_gt;
        cmd_o.push_cur = !sts_i.top_gt;
      end
      itp_pkg::ST_DRAIN_RD: begin
        cmd_o.rd_stk   = !sts_i.depth_zero;
        cmd_o.ld_k_out = sts_i.depth_zero;
      end
      itp_pkg::ST_DRAIN_EX: begin
        cmd_o.pop       = 1'b1;
        cmd_o.set_paren = sts_i.top_open;
        cmd_o.emit_top  = !sts_i.top_open;
      end
      itp_pkg::ST_OUT_EMPTY: begin
        cmd_o.load_empty = sts_i.out_free;
        cmd_o.clr        = sts_i.out_free;
      end
      itp_pkg::ST_OUT_RD: begin
        cmd_o.rd_out = sts_i.out_free;
      end
      itp_pkg::ST_OUT_LD: begin
        cmd_o.load_out = 1'b1;
        cmd_o.clr      = sts_i.k_zero;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  `ITP_ASSERT_IMPL(a_ld_after_rd, state_q == itp_pkg::ST_OUT_LD,
                   $past(state_q) == itp_pkg::ST_OUT_RD, "output load without buffer read")
  `ITP_ASSERT_NEXT(a_last_to_load, state_q == itp_pkg::ST_OUT_LD && sts_i.k_zero,
                   state_q == itp_pkg::ST_LOAD, "no return to load after last transaction")
  `ITP_ASSERT_IMPL(a_stall_out_of_load, state_q != itp_pkg::ST_LOAD, in_stall_o,
                   "input taken outside the load phase")

endmodule

`default_nettype wire

[rtl/infix_to_prefix_converter.sv]
// Infix-to-prefix converter: one character per input transaction, last marked.
// After the end mark the expression is scanned in reverse with an operator
// stack (shunting yard) and the prefix string is emitted one character per
// output transaction, final one marked by last_out_o.
// Input: in_valid_i/in_stall_o with char_in_i and end_of_expr_i; one character
// is taken per cycle while loading. in_stall_o is high from the end mark until
// the final result transaction is in the output register.
// Conversion: each scanned character, each operator or closing-parenthesis
// step and each stack pop is a read state followed by an execute state, and
// the drain follows the scan; each step is bound by the registered RAM reads.
// Emission: each result character is a read of the output buffer RAM, then a
// load of the output register; an empty result gives one transaction with
// empty_out_o set. status_o is the same on every transaction of an expression.
// Output: out_valid_o/out_stall_i; a held transaction stays stable while
// stalled, and the next expression may load while the last one waits.
// Reset clears counts, flags and the output valid flag; buffer contents are not
// cleared and need no clearing pass.
// Depends on itp_pkg, itp_ram, itp_dp and itp_ctrl.
`default_nettype none

module infix_to_prefix_converter #(
  parameter int unsigned MAX_LEN = 64
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] char_in_i,
  input  wire logic       end_of_expr_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic      [7:0] char_out_o,
  output logic            last_out_o,
  output logic            empty_out_o,
  output logic      [1:0] status_o
);

  itp_pkg::itp_cmd_t cmd;
  itp_pkg::itp_sts_t sts;

  itp_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .end_of_expr_i (end_of_expr_i),
    .in_stall_o    (in_stall_o),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  itp_dp #(.MAX_LEN(MAX_LEN)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .char_in_i   (char_in_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .char_out_o  (char_out_o),
    .last_out_o  (last_out_o),
    .empty_out_o (empty_out_o),
    .status_o    (status_o)
  );

endmodule

`default_nettype wire

[sim/infix_to_prefix_checker.sv]
// Checker for the infix-to-prefix converter: watches both channels, predicts
// the prefix characters of each expression and compares them in order.
// Depends on itp_pkg for character and status constants.
module infix_to_prefix_checker #(
  parameter int unsigned MAX_LEN = 64
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic       in_stall_i,
  input  wire logic [7:0] char_in_i,
  input  wire logic       end_of_expr_i,
  input  wire logic       out_valid_i,
  input  wire logic       out_stall_i,
  input  wire logic [7:0] char_out_i,
  input  wire logic       last_out_i,
  input  wire logic       empty_out_i,
  input  wire logic [1:0] status_i,
  output int              mismatches_o,
  output int              pending_o,
  output int              checked_o,
  output int              trunc_o,
  output int              paren_o
);

  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       empty;
    logic [1:0] st;
  } prefix_char_t;

  logic [7:0]   infix_buf [MAX_LEN];
  int unsigned  infix_len = 0;
  bit           paren_err = 1'b0;
  bit           trunc_err = 1'b0;
  prefix_char_t prefix_q [$];
  prefix_char_t got;
  prefix_char_t want;

  int mismatch_cnt = 0;
  int pending_cnt  = 0;
  int checked_cnt  = 0;
  int trunc_cnt    = 0;
  int paren_cnt    = 0;

  assign mismatches_o = mismatch_cnt;
  assign pending_o    = pending_cnt;
  assign checked_o    = checked_cnt;
  assign trunc_o      = trunc_cnt;
  assign paren_o      = paren_cnt;

  function automatic bit is_operand(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic int op_rank(input logic [7:0] c);
    case (c)
      itp_pkg::CH_PLUS, itp_pkg::CH_MINUS: return 1;
      itp_pkg::CH_STAR, itp_pkg::CH_SLASH: return 2;
      itp_pkg::CH_CARET:                   return 3;
      default:                             return 0;
    endcase
  endfunction

  task automatic convert_expression();
    logic [7:0] opstack [MAX_LEN];
    logic [7:0] revout [MAX_LEN];
    int         sp;
    int         n_out;
    int         k;
    logic [7:0] c;
    bit         matched;
    logic [1:0] st;
    sp    = 0;
    n_out = 0;
    for (k = int'(infix_len) - 1; k >= 0; k--) begin
      c = infix_buf[k];
      if (c == itp_pkg::CH_LPAREN) begin
        c = itp_pkg::CH_RPAREN;
      end else if (c == itp_pkg::CH_RPAREN) begin
        c = itp_pkg::CH_LPAREN;
      end
      if (is_operand(c)) begin
        if (n_out < MAX_LEN) begin
          revout[n_out] = c;
          n_out++;
        end
      end else if (c == itp_pkg::CH_LPAREN) begin
        if (sp < MAX_LEN) begin
          opstack[sp] = c;
          sp++;
        end
      end else if (c == itp_pkg::CH_RPAREN) begin
        matched = 1'b0;
        while (sp > 0 && !matched) begin
          sp--;
          if (opstack[sp] == itp_pkg::CH_LPAREN) begin
            matched = 1'b1;
          end else if (n_out < MAX_LEN) begin
            revout[n_out] = opstack[sp];
            n_out++;
          end
        end
        if (!matched) paren_err = 1'b1;
      end else begin
        while (sp > 0 && op_rank(opstack[sp-1]) > op_rank(c)) begin
          sp--;
          if (n_out < MAX_LEN) begin
            revout[n_out] = opstack[sp];
            n_out++;
          end
        end
        if (sp < MAX_LEN) begin
          opstack[sp] = c;
          sp++;
        end
      end
    end
    while (sp > 0) begin
      sp--;
      if (opstack[sp] == itp_pkg::CH_LPAREN) begin
        paren_err = 1'b1;
      end else if (n_out < MAX_LEN) begin
        revout[n_out] = opstack[sp];
        n_out++;
      end
    end
    st = trunc_err ? itp_pkg::STATUS_TRUNC :
         (paren_err ? itp_pkg::STATUS_PAREN : itp_pkg::STATUS_OK);
    if (n_out == 0) begin
      prefix_q.push_back('{ch: itp_pkg::CH_NUL, last: 1'b1, empty: 1'b1, st: st});
    end else begin
      for (k = n_out - 1; k >= 0; k--) begin
        prefix_q.push_back('{ch: revout[k], last: (k == 0), empty: 1'b0, st: st});
      end
    end
    if (trunc_err) trunc_cnt++;
    if (paren_err) paren_cnt++;
    infix_len = 0;
    paren_err = 1'b0;
    trunc_err = 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        got = '{ch: char_out_i, last: last_out_i, empty: empty_out_i, st: status_i};
        checked_cnt++;
        if (prefix_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= REPORT_MAX) begin
            $display("unexpected result transaction: char=%02h last=%0b empty=%0b status=%0d",
                     got.ch, got.last, got.empty, got.st);
          end
        end else begin
          want = prefix_q.pop_front();
          if (got !== want) begin
            mismatch_cnt++;
            if (mismatch_cnt <= REPORT_MAX) begin
              $display("mismatch: expected char=%02h last=%0b empty=%0b status=%0d",
                       want.ch, want.last, want.empty, want.st);
              $display("          actual   char=%02h last=%0b empty=%0b status=%0d",
                       got.ch, got.last, got.empty, got.st);
            end
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (infix_len < MAX_LEN) begin
          infix_buf[infix_len] = char_in_i;
          infix_len++;
        end else begin
          trunc_err = 1'b1;
        end
        if (end_of_expr_i) convert_expression();
      end
      pending_cnt = prefix_q.size();
    end
  end

endmodule

[sim/tb_infix_to_prefix_converter.sv]
// Testbench top for the infix-to-prefix converter: clock, reset, expression
// stimulus with bursty sender and stalling receiver, watchdog and verdict.
// Depends on itp_pkg, infix_to_prefix_converter and infix_to_prefix_checker.
module tb_infix_to_prefix_converter;

  localparam int          RANDOM_CHARS   = 430;
  localparam int          WATCHDOG_LIMIT = 5000;
  localparam int          END_WAIT       = 300;
  localparam logic [7:0]  CH_PERCENT     = 8'h25;

  typedef enum int {RX_READY, RX_RANDOM, RX_PERIODIC, RX_HEAVY} rx_mode_e;

  logic       clk_i;
  logic       rst_ni      = 1'b0;
  logic       in_valid    = 1'b0;
  logic       in_stall;
  logic [7:0] char_in     = 8'h00;
  logic       end_of_expr = 1'b0;
  logic       out_valid;
  logic       out_stall   = 1'b0;
  logic [7:0] char_out;
  logic       last_out;
  logic       empty_out;
  logic [1:0] status;

  int mismatches;
  int pending;
  int checked;
  int trunc_seen;
  int paren_seen;

  int         chars_sent  = 0;
  int         exprs_sent  = 0;
  int         burst_left  = 0;
  int         idle_cycles = 0;
  int         stall_run   = 0;
  int         stall_phase = 0;
  rx_mode_e   rx_mode     = RX_READY;
  logic [7:0] expr_q [$];

  infix_to_prefix_converter dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .char_in_i    (char_in),
    .end_of_expr_i(end_of_expr),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .char_out_o   (char_out),
    .last_out_o   (last_out),
    .empty_out_o  (empty_out),
    .status_o     (status)
  );

  infix_to_prefix_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .char_in_i    (char_in),
    .end_of_expr_i(end_of_expr),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .char_out_i   (char_out),
    .last_out_i   (last_out),
    .empty_out_i  (empty_out),
    .status_i     (status),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .checked_o    (checked),
    .trunc_o      (trunc_seen),
    .paren_o      (paren_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    if (stall_run == 0) begin
      rx_mode   = rx_mode_e'($urandom_range(0, 3));
      stall_run = $urandom_range(20, 200);
    end
    stall_run--;
    stall_phase++;
    case (rx_mode)
      RX_READY:    out_stall <= 1'b0;
      RX_RANDOM:   out_stall <= $urandom_range(0, 1);
      RX_PERIODIC: out_stall <= (stall_phase % 16) < 11;
      default:     out_stall <= $urandom_range(0, 9) < 8;
    endcase
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", idle_cycles);
        $display("[infix_to_prefix_converter] ERROR");
        $finish;
      end
    end
  end

  task automatic send_expr();
    int i;
    for (i = 0; i < expr_q.size(); i++) begin
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk_i);
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                 : $urandom_range(1, 24);
      end
      in_valid    <= 1'b1;
      char_in     <= expr_q[i];
      end_of_expr <= (i == expr_q.size() - 1);
      do @(posedge clk_i); while (in_stall);
      @(negedge clk_i);
      burst_left--;
      chars_sent++;
    end
    exprs_sent++;
    expr_q.delete();
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic load_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) expr_q.push_back(s[i]);
  endtask

  function automatic logic [7:0] pick_operand();
    int r;
    r = $urandom_range(0, 61);
    if (r < 10) return 8'h30 + 8'(r);
    if (r < 36) return 8'h41 + 8'(r - 10);
    return 8'h61 + 8'(r - 36);
  endfunction

  function automatic logic [7:0] pick_operator();
    case ($urandom_range(0, 11))
      0, 5:    return itp_pkg::CH_PLUS;
      1, 8:    return itp_pkg::CH_MINUS;
      2, 6:    return itp_pkg::CH_STAR;
      3, 9:    return itp_pkg::CH_SLASH;
      4, 7:    return itp_pkg::CH_CARET;
      10:      return CH_PERCENT;
      default: return $urandom_range(0, 1) ? itp_pkg::CH_NUL : 8'($urandom_range(128, 255));
    endcase
  endfunction

  task automatic build_well_formed(input int n_operands);
    int i;
    int depth;
    depth = 0;
    for (i = 0; i < n_operands; i++) begin
      while ($urandom_range(0, 3) == 0 && depth < 6) begin
        expr_q.push_back(itp_pkg::CH_LPAREN);
        depth++;
      end
      expr_q.push_back(pick_operand());
      while (depth > 0 && $urandom_range(0, 2) == 0) begin
        expr_q.push_back(itp_pkg::CH_RPAREN);
        depth--;
      end
      if (i < n_operands - 1) expr_q.push_back(pick_operator());
    end
    while (depth > 0) begin
      expr_q.push_back(itp_pkg::CH_RPAREN);
      depth--;
    end
  endtask

  task automatic break_expr();
    int idx;
    idx = $urandom_range(0, expr_q.size() - 1);
    case ($urandom_range(0, 2))
      0:       if (expr_q.size() > 1) expr_q.delete(idx);
      1:       expr_q.insert(idx, itp_pkg::CH_LPAREN);
      default: expr_q.insert(idx, itp_pkg::CH_RPAREN);
    endcase
  endtask

  task automatic build_noise(input int len);
    int i;
    for (i = 0; i < len; i++) expr_q.push_back(8'($urandom_range(0, 255)));
  endtask

  initial begin
    int directed_chars;
    int pick;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    load_text("a");           send_expr();
    load_text(")");           send_expr();
    load_text("(");           send_expr();
    load_text("+");           send_expr();
    expr_q.push_back(itp_pkg::CH_NUL); send_expr();
    expr_q.push_back(8'hFF);  send_expr();
    load_text("a+b*c^d-e/f"); send_expr();
    load_text("(a)");         send_expr();
    load_text("a)");          send_expr();
    load_text("()");          send_expr();
    load_text("Z9");          send_expr();
    drain_results();
    directed_chars = chars_sent;

    while (chars_sent < directed_chars + RANDOM_CHARS) begin
      pick = $urandom_range(0, 99);
      if (exprs_sent == 18 || exprs_sent == 40) begin
        build_well_formed($urandom_range(34, 45));
        if (exprs_sent == 40) break_expr();
      end else if (pick < 70) begin
        build_well_formed($urandom_range(1, 8));
      end else if (pick < 82) begin
        build_well_formed($urandom_range(1, 8));
        break_expr();
      end else if (pick < 94) begin
        build_noise($urandom_range(1, 10));
      end else begin
        expr_q.push_back($urandom_range(0, 1) ? pick_operand() : pick_operator());
      end
      send_expr();
      if (exprs_sent % 15 == 0) drain_results();
    end

    drain_results();
    repeat (END_WAIT) @(negedge clk_i);
    $display("sent %0d expressions (%0d characters), %0d truncated, %0d with paren errors",
             exprs_sent, chars_sent, trunc_seen, paren_seen);
    $display("checked %0d prefix characters, %0d mismatches, %0d still expected",
             checked, mismatches, pending);
    if (mismatches == 0 && pending == 0) begin
      $display("[infix_to_prefix_converter] OK");
    end else begin
      $display("[infix_to_prefix_converter] ERROR");
    end
    $finish;
  end

endmodule
